/* hw/rtl/mjs_pkg.sv */
// mjs_pkg: shared types, codes and the control store of the jarring sequencer
// used by mjs_useq, mjs_div and motor_jarring_sequencer; no dependencies
package mjs_pkg;

    // sequencer phases held between ticks
    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_ARM        = 4'd1,
        PH_PAUSE      = 4'd2,
        PH_CONFIGURE  = 4'd3,
        PH_SET_FIRST  = 4'd4,
        PH_WAIT_FIRST = 4'd5,
        PH_SET_SECOND = 4'd6,
        PH_WAIT_SECOND = 4'd7,
        PH_COUNT      = 4'd8,
        PH_RESTORE    = 4'd9
    } phase_t;

    // result command codes
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_SET_FREQ = 2'd1;
    localparam logic [1:0] CMD_APPLY    = 2'd2;
    localparam logic [1:0] CMD_RESTORE  = 2'd3;

    // result event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_FIRST  = 2'd1;
    localparam logic [1:0] EV_SECOND = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_ENABLED   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREQ     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_FREQ    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SECONDS = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JAR_COUNT      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_RATE        = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_RATE      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ      = 4'd7;
    localparam int CFG_DATA_W = 16;

    // field widths
    localparam int FREQ_W = 15;
    localparam int RAMP_W = 21;
    localparam int TIME_W = 32;
    localparam int PER_W  = 16;
    localparam int CNT_W  = 10;

    // divider dividend is base_freq * 100
    localparam int DVD_W = 22;
    localparam logic [DVD_W-1:0] RAMP_SCALE = 22'd100;

    // micro-operations driven into the datapath
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LATCH_IN,
        OP_RESOLVE,
        OP_DIV_UP,
        OP_DIV_DOWN,
        OP_EXEC
    } uop_t;

    // jump conditions: jump when true, else fall through
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_INPUT,
        JC_NOT_CONFIG,
        JC_DIV_BUSY,
        JC_OUT_BLOCKED
    } jcond_t;

    localparam int UPC_W = 3;

    typedef struct packed {
        uop_t             op;
        jcond_t           jc;
        logic [UPC_W-1:0] target;
    } ucw_t;

    // status flags fed back to the sequencer
    typedef struct packed {
        logic no_input;
        logic not_config;
        logic div_busy;
        logic out_blocked;
    } ucond_t;

    // control store
    localparam logic [UPC_W-1:0] UA_FETCH   = 3'd0;
    localparam logic [UPC_W-1:0] UA_WAIT_UP = 3'd3;
    localparam logic [UPC_W-1:0] UA_WAIT_DN = 3'd5;
    localparam logic [UPC_W-1:0] UA_EXEC    = 3'd6;

    function automatic ucw_t mjs_rom(input logic [UPC_W-1:0] addr);
        ucw_t w;
        begin
            case (addr)
                3'd0: w = '{op: OP_LATCH_IN, jc: JC_NO_INPUT,    target: UA_FETCH};
                3'd1: w = '{op: OP_RESOLVE,  jc: JC_NOT_CONFIG,  target: UA_EXEC};
                3'd2: w = '{op: OP_DIV_UP,   jc: JC_NEVER,       target: UA_FETCH};
                3'd3: w = '{op: OP_NOP,      jc: JC_DIV_BUSY,    target: UA_WAIT_UP};
                3'd4: w = '{op: OP_DIV_DOWN, jc: JC_NEVER,       target: UA_FETCH};
                3'd5: w = '{op: OP_NOP,      jc: JC_DIV_BUSY,    target: UA_WAIT_DN};
                3'd6: w = '{op: OP_EXEC,     jc: JC_OUT_BLOCKED, target: UA_EXEC};
                default: w = '{op: OP_NOP,   jc: JC_ALWAYS,      target: UA_FETCH};
            endcase
            return w;
        end
    endfunction

endpackage

/* hw/rtl/mjs_useq.sv */
// mjs_useq: step counter and control store lookup of the jarring sequencer
// depends on mjs_pkg
module mjs_useq (
    input  logic           aclk,
    input  logic           aresetn,
    input  mjs_pkg::ucond_t cond,
    output mjs_pkg::ucw_t   ucw
);

    logic [mjs_pkg::UPC_W-1:0] upc_reg, upc_next;
    logic                      take;

    assign ucw = mjs_pkg::mjs_rom(upc_reg);

    // jump condition select
    always_comb begin
        case (ucw.jc)
            mjs_pkg::JC_NEVER:       take = 1'b0;
            mjs_pkg::JC_ALWAYS:      take = 1'b1;
            mjs_pkg::JC_NO_INPUT:    take = cond.no_input;
            mjs_pkg::JC_NOT_CONFIG:  take = cond.not_config;
            mjs_pkg::JC_DIV_BUSY:    take = cond.div_busy;
            mjs_pkg::JC_OUT_BLOCKED: take = cond.out_blocked;
            default:                 take = 1'b1;
        endcase
        upc_next = take ? ucw.target : upc_reg + 1'b1;
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= mjs_pkg::UA_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* hw/rtl/mjs_div.sv */
// mjs_div: serial restoring divider for ramp times, (base * 100) / rate
// one quotient bit per cycle, saturated to the ramp width; depends on mjs_pkg
module mjs_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mjs_pkg::FREQ_W-1:0]    base,
    input  logic [mjs_pkg::FREQ_W-1:0]    divisor,
    output logic                          busy,
    output logic [mjs_pkg::RAMP_W-1:0]    quotient
);

    localparam int CW = $clog2(mjs_pkg::DVD_W + 1);

    logic [mjs_pkg::FREQ_W-1:0] div_reg;
    logic [mjs_pkg::FREQ_W-1:0] rem_reg;
    logic [mjs_pkg::DVD_W-1:0]  quo_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic [mjs_pkg::FREQ_W:0]   trial;
    logic                       fits;
    logic [mjs_pkg::FREQ_W:0]   diff;

    // trial subtract of one step
    always_comb begin
        trial = {rem_reg, quo_reg[mjs_pkg::DVD_W-1]};
        fits  = trial >= {1'b0, div_reg};
        diff  = trial - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(mjs_pkg::DVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // shift register carries dividend bits out and quotient bits in
    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= mjs_pkg::DVD_W'(base) * mjs_pkg::RAMP_SCALE;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[mjs_pkg::FREQ_W-1:0] : trial[mjs_pkg::FREQ_W-1:0];
            quo_reg <= {quo_reg[mjs_pkg::DVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = (|quo_reg[mjs_pkg::DVD_W-1:mjs_pkg::RAMP_W]) ? '1
                                                                   : quo_reg[mjs_pkg::RAMP_W-1:0];

endmodule

/* hw/rtl/motor_jarring_sequencer.sv */
// motor_jarring_sequencer: top level, config registers, datapath, output register
// depends on mjs_pkg, mjs_useq, mjs_div
//
// Usage: each input word is one control tick with motor status, time and the
// drive's present limits, ramps and setpoint. Every accepted tick gives
// exactly one result word on the m_ channel: a command with its values, the
// event seen and the phase after the tick. Configuration words go through
// cfg_valid/cfg_ready (ready whenever out of reset); the user must write them
// only while idle, which the block itself does not enforce.
// Program: a microcoded step counter runs a short program per tick. An
// ordinary tick is latched, its phase resolved and its result written to the
// output register in the execute step; the next tick is accepted once the
// program is back at the fetch step. The configure tick runs the serial
// divider twice (one quotient bit per cycle) between resolve and execute, for
// the up and down ramps; each zero rate skips its division.
// The result sits in an output register; the next tick is accepted while it
// waits. If the receiver stalls, the next result waits in the execute step
// and s_ready stays low until the output register is free.
// Reset (aresetn low, synchronous) returns the phase to idle, clears the
// counters and the configuration (base_freq to 5000) and empties the output.
module motor_jarring_sequencer #(
    parameter int RETRY_LIMIT = 30
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mjs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mjs_pkg::CFG_DATA_W-1:0]    cfg_data,
    // tick input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_motor_stopped,
    input  logic                              s_motor_running,
    input  logic [mjs_pkg::TIME_W-1:0]        s_now_seconds,
    input  logic                              s_setpoint_reached,
    input  logic [mjs_pkg::FREQ_W-1:0]        s_measured_freq,
    input  logic [mjs_pkg::FREQ_W-1:0]        s_drive_low_limit,
    input  logic [mjs_pkg::FREQ_W-1:0]        s_drive_high_limit,
    input  logic [mjs_pkg::RAMP_W-1:0]        s_drive_ramp_up,
    input  logic [mjs_pkg::RAMP_W-1:0]        s_drive_ramp_down,
    input  logic [mjs_pkg::FREQ_W-1:0]        s_drive_setpoint,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_command,
    output logic [mjs_pkg::FREQ_W-1:0]        m_freq_cmd,
    output logic [mjs_pkg::FREQ_W-1:0]        m_min_freq_cmd,
    output logic [mjs_pkg::FREQ_W-1:0]        m_max_freq_cmd,
    output logic [mjs_pkg::RAMP_W-1:0]        m_ramp_up_cmd,
    output logic                              m_ramp_up_valid,
    output logic [mjs_pkg::RAMP_W-1:0]        m_ramp_down_cmd,
    output logic                              m_ramp_down_valid,
    output logic [1:0]                        m_event_res,
    output logic [3:0]                        m_phase
);

    localparam int RW = $clog2(RETRY_LIMIT + 2);
    localparam int FW = mjs_pkg::FREQ_W;
    localparam int AW = mjs_pkg::RAMP_W;

    // configuration registers
    logic                     mode_enabled_reg;
    logic [FW-1:0]            first_freq_reg, second_freq_reg;
    logic [mjs_pkg::PER_W-1:0] period_seconds_reg;
    logic [mjs_pkg::CNT_W-1:0] jar_count_reg;
    logic [FW-1:0]            up_rate_reg, down_rate_reg, base_freq_reg;

    // sequencer state
    mjs_pkg::phase_t           phase_reg, phase_next;
    logic [mjs_pkg::TIME_W-1:0] period_start_reg, period_start_next;
    logic [mjs_pkg::CNT_W-1:0]  swings_done_reg, swings_done_next;
    logic [RW-1:0]             retry_wait_reg, retry_wait_next;
    logic [FW-1:0]             saved_low_reg, saved_high_reg, saved_set_reg;
    logic [AW-1:0]             saved_up_reg, saved_down_reg;
    logic [AW-1:0]             ramp_up_q_reg;

    // latched tick
    logic                      in_stopped_reg, in_running_reg, in_reached_reg;
    logic [mjs_pkg::TIME_W-1:0] in_now_reg;
    logic [FW-1:0]             in_meas_reg, in_low_reg, in_high_reg, in_set_reg;
    logic [AW-1:0]             in_up_reg, in_down_reg;

    // output register
    logic                      m_valid_reg;
    logic [1:0]                cmd_reg, cmd_next, ev_reg, ev_next;
    logic [FW-1:0]             freq_reg, freq_next, min_reg, min_next, max_reg, max_next;
    logic [AW-1:0]             up_reg, up_next, down_reg, down_next;
    logic                      upv_reg, upv_next, dnv_reg, dnv_next;
    logic [3:0]                ph_out_reg;

    mjs_pkg::ucw_t   ucw;
    mjs_pkg::ucond_t cond;
    logic            div_start, div_busy;
    logic [FW-1:0]   div_divisor;
    logic [AW-1:0]   div_q;
    logic            forced;
    mjs_pkg::phase_t eff_phase;
    logic            out_blocked;
    logic            exec_fire;

    // sequencer and divider
    mjs_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .ucw     (ucw)
    );

    mjs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .base     (base_freq_reg),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // forced restore on mode off or stopped motor past the pause
    assign forced    = (!mode_enabled_reg || in_stopped_reg) && (phase_reg > mjs_pkg::PH_PAUSE);
    assign eff_phase = forced ? mjs_pkg::PH_RESTORE : phase_reg;

    assign out_blocked = m_valid_reg && !m_ready;
    assign exec_fire   = (ucw.op == mjs_pkg::OP_EXEC) && !out_blocked;

    assign s_ready   = aresetn && (ucw.op == mjs_pkg::OP_LATCH_IN);
    assign cfg_ready = aresetn;

    assign cond.no_input    = !s_valid;
    assign cond.not_config  = (eff_phase != mjs_pkg::PH_CONFIGURE);
    assign cond.div_busy    = div_busy;
    assign cond.out_blocked = out_blocked;

    // divider launch, skipped for a zero rate
    always_comb begin
        div_start   = 1'b0;
        div_divisor = up_rate_reg;
        case (ucw.op)
            mjs_pkg::OP_DIV_UP: begin
                div_divisor = up_rate_reg;
                div_start   = |up_rate_reg;
            end
            mjs_pkg::OP_DIV_DOWN: begin
                div_divisor = down_rate_reg;
                div_start   = |down_rate_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_enabled_reg   <= 1'b0;
            first_freq_reg     <= '0;
            second_freq_reg    <= '0;
            period_seconds_reg <= '0;
            jar_count_reg      <= '0;
            up_rate_reg        <= '0;
            down_rate_reg      <= '0;
            base_freq_reg      <= FW'(5000);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mjs_pkg::CFG_MODE_ENABLED:   mode_enabled_reg   <= cfg_data[0];
                mjs_pkg::CFG_FIRST_FREQ:     first_freq_reg     <= cfg_data[FW-1:0];
                mjs_pkg::CFG_SECOND_FREQ:    second_freq_reg    <= cfg_data[FW-1:0];
                mjs_pkg::CFG_PERIOD_SECONDS: period_seconds_reg <= cfg_data[mjs_pkg::PER_W-1:0];
                mjs_pkg::CFG_JAR_COUNT:      jar_count_reg      <= cfg_data[mjs_pkg::CNT_W-1:0];
                mjs_pkg::CFG_UP_RATE:        up_rate_reg        <= cfg_data[FW-1:0];
                mjs_pkg::CFG_DOWN_RATE:      down_rate_reg      <= cfg_data[FW-1:0];
                mjs_pkg::CFG_BASE_FREQ:      base_freq_reg      <= cfg_data[FW-1:0];
                default: begin
                end
            endcase
        end
    end

    // tick latch
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_stopped_reg <= s_motor_stopped;
            in_running_reg <= s_motor_running;
            in_now_reg     <= s_now_seconds;
            in_reached_reg <= s_setpoint_reached;
            in_meas_reg    <= s_measured_freq;
            in_low_reg     <= s_drive_low_limit;
            in_high_reg    <= s_drive_high_limit;
            in_up_reg      <= s_drive_ramp_up;
            in_down_reg    <= s_drive_ramp_down;
            in_set_reg     <= s_drive_setpoint;
        end
        if (ucw.op == mjs_pkg::OP_DIV_DOWN) begin
            ramp_up_q_reg <= div_q;
        end
    end

    // phase step of one tick
    always_comb begin
        logic [FW-1:0]             target;
        logic [RW-1:0]             retry_inc;
        logic [mjs_pkg::CNT_W-1:0] swings_inc;
        logic [mjs_pkg::TIME_W-1:0] elapsed;
        logic [FW-1:0]             lo_ff, hi_ff;

        target     = (phase_reg == mjs_pkg::PH_WAIT_FIRST) ? first_freq_reg : second_freq_reg;
        retry_inc  = retry_wait_reg + 1'b1;
        swings_inc = swings_done_reg + 1'b1;
        elapsed    = in_now_reg - period_start_reg;
        lo_ff      = (first_freq_reg < second_freq_reg) ? first_freq_reg : second_freq_reg;
        hi_ff      = (first_freq_reg > second_freq_reg) ? first_freq_reg : second_freq_reg;

        phase_next        = phase_reg;
        period_start_next = period_start_reg;
        swings_done_next  = swings_done_reg;
        retry_wait_next   = retry_wait_reg;
        cmd_next  = mjs_pkg::CMD_NONE;
        ev_next   = mjs_pkg::EV_NONE;
        freq_next = '0;
        min_next  = '0;
        max_next  = '0;
        up_next   = '0;
        upv_next  = 1'b0;
        down_next = '0;
        dnv_next  = 1'b0;

        case (phase_reg)
            mjs_pkg::PH_IDLE: begin
                if (mode_enabled_reg && in_running_reg) begin
                    phase_next = mjs_pkg::PH_ARM;
                end
            end
            mjs_pkg::PH_ARM: begin
                period_start_next = in_now_reg;
                phase_next        = mjs_pkg::PH_PAUSE;
            end
            mjs_pkg::PH_PAUSE: begin
                if (elapsed > mjs_pkg::TIME_W'(period_seconds_reg)) begin
                    phase_next = mjs_pkg::PH_CONFIGURE;
                end
            end
            mjs_pkg::PH_CONFIGURE: begin
                cmd_next   = mjs_pkg::CMD_APPLY;
                min_next   = (in_high_reg < lo_ff) ? in_high_reg : lo_ff;
                max_next   = (in_low_reg > hi_ff) ? in_low_reg : hi_ff;
                if (|up_rate_reg) begin
                    up_next  = ramp_up_q_reg;
                    upv_next = 1'b1;
                end
                if (|down_rate_reg) begin
                    down_next = div_q;
                    dnv_next  = 1'b1;
                end
                phase_next = mjs_pkg::PH_SET_FIRST;
            end
            mjs_pkg::PH_SET_FIRST, mjs_pkg::PH_SET_SECOND: begin
                cmd_next   = mjs_pkg::CMD_SET_FREQ;
                freq_next  = (phase_reg == mjs_pkg::PH_SET_FIRST) ? first_freq_reg
                                                                  : second_freq_reg;
                phase_next = mjs_pkg::phase_t'(phase_reg + 4'd1);
            end
            mjs_pkg::PH_WAIT_FIRST, mjs_pkg::PH_WAIT_SECOND: begin
                if (in_reached_reg && (in_meas_reg == target)) begin
                    ev_next    = (phase_reg == mjs_pkg::PH_WAIT_FIRST) ? mjs_pkg::EV_FIRST
                                                                       : mjs_pkg::EV_SECOND;
                    phase_next = mjs_pkg::phase_t'(phase_reg + 4'd1);
                end else if (retry_inc > RW'(RETRY_LIMIT)) begin
                    retry_wait_next = '0;
                    phase_next      = mjs_pkg::phase_t'(phase_reg - 4'd1);
                end else begin
                    retry_wait_next = retry_inc;
                end
            end
            mjs_pkg::PH_COUNT: begin
                if (swings_inc >= jar_count_reg) begin
                    swings_done_next = '0;
                    phase_next       = mjs_pkg::PH_RESTORE;
                end else begin
                    swings_done_next = swings_inc;
                    phase_next       = mjs_pkg::PH_SET_FIRST;
                end
            end
            mjs_pkg::PH_RESTORE: begin
                cmd_next   = mjs_pkg::CMD_RESTORE;
                freq_next  = saved_set_reg;
                min_next   = saved_low_reg;
                max_next   = saved_high_reg;
                up_next    = saved_up_reg;
                upv_next   = 1'b1;
                down_next  = saved_down_reg;
                dnv_next   = 1'b1;
                phase_next = mjs_pkg::PH_IDLE;
            end
            default: begin
                phase_next = mjs_pkg::PH_IDLE;
            end
        endcase
    end

    // sequencer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= mjs_pkg::PH_IDLE;
            period_start_reg <= '0;
            swings_done_reg  <= '0;
            retry_wait_reg   <= '0;
        end else if (ucw.op == mjs_pkg::OP_RESOLVE) begin
            phase_reg <= eff_phase;
        end else if (exec_fire) begin
            phase_reg        <= phase_next;
            period_start_reg <= period_start_next;
            swings_done_reg  <= swings_done_next;
            retry_wait_reg   <= retry_wait_next;
        end
    end

    // saved drive settings, written on the configure tick
    always_ff @(posedge aclk) begin
        if (exec_fire && (phase_reg == mjs_pkg::PH_CONFIGURE)) begin
            saved_low_reg  <= in_low_reg;
            saved_high_reg <= in_high_reg;
            saved_up_reg   <= in_up_reg;
            saved_down_reg <= in_down_reg;
            saved_set_reg  <= in_set_reg;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            cmd_reg    <= cmd_next;
            freq_reg   <= freq_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            up_reg     <= up_next;
            upv_reg    <= upv_next;
            down_reg   <= down_next;
            dnv_reg    <= dnv_next;
            ev_reg     <= ev_next;
            ph_out_reg <= phase_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_command         = cmd_reg;
    assign m_freq_cmd        = freq_reg;
    assign m_min_freq_cmd    = min_reg;
    assign m_max_freq_cmd    = max_reg;
    assign m_ramp_up_cmd     = up_reg;
    assign m_ramp_up_valid   = upv_reg;
    assign m_ramp_down_cmd   = down_reg;
    assign m_ramp_down_valid = dnv_reg;
    assign m_event_res       = ev_reg;
    assign m_phase           = ph_out_reg;

endmodule
